// ----- hw/rtl/vga_planar_memory_access_top_macros.svh -----
// ----------------------------------------------------------------------------
// vga_planar_memory_access_top_macros
// Assertion macros for the planar memory access block. Define ASSERT_OFF to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef VGA_PLANAR_MEMORY_ACCESS_TOP_MACROS_SVH
`define VGA_PLANAR_MEMORY_ACCESS_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled in reset
`define VPMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define VPMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define VPMA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VPMA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/vpma_pkg.sv -----
// ----------------------------------------------------------------------------
// vpma_pkg
// Types, port numbers and register masks of the planar memory access block.
// ----------------------------------------------------------------------------
`default_nettype none

package vpma_pkg;

	// item operation codes
	typedef enum logic [1:0] {
		OP_PORT  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_UNSUP = 2'd3
	} vpma_op_t;

	// controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} vpma_state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic exec;
	} vpma_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
	} vpma_sts_t;

	localparam logic [16:0] PORT_SEQ_INDEX = 17'h003c4;
	localparam logic [16:0] PORT_SEQ_DATA  = 17'h003c5;
	localparam logic [16:0] PORT_GFX_INDEX = 17'h003ce;
	localparam logic [16:0] PORT_GFX_DATA  = 17'h003cf;

	localparam int SEQ_REGS = 8;
	localparam int GFX_REGS = 9;
	localparam logic [7:0] GFX_REGS_B = 8'd9;

	localparam logic [7:0] GFX6_STD = 8'h05;

	// implemented bits of each sequencer register
	function automatic logic [7:0] seq_wmask(input logic [2:0] idx);
		logic [7:0] m;
		case (idx)
			3'd0: m = 8'h03;
			3'd1: m = 8'h3d;
			3'd2: m = 8'h0f;
			3'd3: m = 8'h3f;
			3'd4: m = 8'h0e;
			3'd7: m = 8'hff;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	// implemented bits of each graphics register
	function automatic logic [7:0] gfx_wmask(input logic [3:0] idx);
		logic [7:0] m;
		case (idx)
			4'd3: m = 8'h1f;
			4'd4: m = 8'h03;
			4'd5: m = 8'h7b;
			4'd8: m = 8'hff;
			4'd0, 4'd1, 4'd2, 4'd6, 4'd7: m = 8'h0f;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	// expand a plane set into byte lanes
	function automatic logic [31:0] lanes(input logic [3:0] m);
		return {{8{m[3]}}, {8{m[2]}}, {8{m[1]}}, {8{m[0]}}};
	endfunction

	// rotate a byte right
	function automatic logic [7:0] rot8(input logic [7:0] v, input logic [2:0] b);
		logic [15:0] t;
		t = {v, v} >> b;
		return t[7:0];
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vpma_in_if.sv -----
// ----------------------------------------------------------------------------
// vpma_in_if
// Request channel: one byte access per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface vpma_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [16:0] address;
	logic [7:0]  data;

	modport source (output valid, output op, output address, output data, input ready);
	modport sink (input valid, input op, input address, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/vpma_out_if.sv -----
// ----------------------------------------------------------------------------
// vpma_out_if
// Response channel: one result per request beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface vpma_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;
	logic       handled;
	logic       emulating;

	modport source (output valid, output read_byte, output handled, output emulating,
		input ready);
	modport sink (input valid, input read_byte, input handled, input emulating,
		output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/vpma_dp.sv -----
// ----------------------------------------------------------------------------
// vpma_dp
// Datapath: register file, data latch, four-plane video memory, read and
// write mode logic, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module vpma_dp import vpma_pkg::*; #(
	parameter int VRAM_WORDS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  vpma_cmd_t   cmd,
	output vpma_sts_t   sts,
	input  logic [1:0]  in_op,
	input  logic [16:0] in_address,
	input  logic [7:0]  in_data,
	output logic [7:0]  read_byte,
	output logic        handled,
	output logic        emulating
);

	localparam int IW = $clog2(VRAM_WORDS);
	localparam logic [17:0] WORDS1 = 18'(VRAM_WORDS);
	localparam logic [17:0] WORDS2 = 18'(2 * VRAM_WORDS);
	localparam logic [17:0] WORDS3 = 18'(3 * VRAM_WORDS);
	localparam logic [IW-1:0] LAST_WORD = IW'(VRAM_WORDS - 1);

	// architectural state
	logic [7:0]  seq_index_q;
	logic [7:0]  gfx_index_q;
	logic [7:0]  seq_regs_q [SEQ_REGS];
	logic [7:0]  gfx_regs_q [GFX_REGS];
	logic [31:0] latch_q;
	logic        std_mode_q;
	logic        caching_q;
	logic [31:0] vram [VRAM_WORDS];

	// item and memory read stage
	vpma_op_t    op_s1;
	logic [16:0] addr_s1;
	logic [7:0]  data_s1;
	logic [IW-1:0] widx_s1;
	logic [31:0] rdata_q;
	logic [IW-1:0] clr_q;

	// response register
	logic [7:0] read_byte_q;
	logic       handled_q;
	logic       emulating_q;

	logic [15:0] raw_word;
	logic [17:0] raw_ext;
	logic [17:0] wrapped;
	logic [IW-1:0] rd_idx;

	// pick the word index of the incoming access and wrap it into the memory
	always_comb begin
		if (seq_regs_q[4][3]) begin
			raw_word = {2'b00, in_address[15:2]};
		end else if (gfx_regs_q[5][4]) begin
			raw_word = {1'b0, in_address[15:1]};
		end else begin
			raw_word = in_address[15:0];
		end
		raw_ext = {2'b00, raw_word};
		if (raw_ext >= WORDS3) begin
			wrapped = raw_ext - WORDS3;
		end else if (raw_ext >= WORDS2) begin
			wrapped = raw_ext - WORDS2;
		end else if (raw_ext >= WORDS1) begin
			wrapped = raw_ext - WORDS1;
		end else begin
			wrapped = raw_ext;
		end
		rd_idx = wrapped[IW-1:0];
	end

	logic        emu;
	logic        in_win;
	logic        chain4;
	logic        oddeven;
	logic [1:0]  plane;
	logic [3:0]  plane_sel;
	logic [7:0]  plane_byte;
	logic [31:0] cmp;
	logic [7:0]  fold;
	logic [7:0]  rd_byte;
	logic [7:0]  rot;
	logic [7:0]  bm;
	logic [31:0] bm_w;
	logic [31:0] sm;
	logic [31:0] wr_val;
	logic [31:0] wr_mask;
	logic [31:0] merged;
	logic        wr_hit;
	logic        latch_ld;

	// read and write mode logic on the fetched word
	always_comb begin
		emu        = std_mode_q & caching_q;
		in_win     = ~addr_s1[16];
		chain4     = seq_regs_q[4][3];
		oddeven    = gfx_regs_q[5][4];
		plane      = chain4 ? addr_s1[1:0] : {gfx_regs_q[4][1], addr_s1[0]};
		plane_sel  = 4'b0001 << plane;
		plane_byte = rdata_q[{plane, 3'b000} +: 8];

		cmp  = (rdata_q ^ lanes(gfx_regs_q[2][3:0])) & lanes(gfx_regs_q[7][3:0]);
		fold = cmp[7:0] | cmp[15:8] | cmp[23:16] | cmp[31:24];

		if (!in_win) begin
			rd_byte = 8'hff;
		end else if (chain4 || oddeven) begin
			rd_byte = plane_byte;
		end else if (gfx_regs_q[5][3]) begin
			rd_byte = ~fold;
		end else begin
			rd_byte = rdata_q[{gfx_regs_q[4][1:0], 3'b000} +: 8];
		end

		rot  = rot8(data_s1, gfx_regs_q[3][2:0]);
		sm   = lanes(gfx_regs_q[1][3:0]);
		bm   = gfx_regs_q[8];
		case (gfx_regs_q[5][1:0])
			2'd1: wr_val = latch_q;
			2'd2: wr_val = lanes(data_s1[3:0]);
			2'd3: begin
				bm     = gfx_regs_q[8] & rot;
				wr_val = lanes(gfx_regs_q[0][3:0]);
			end
			default: wr_val = ({4{rot}} & ~sm) | (lanes(gfx_regs_q[0][3:0]) & sm);
		endcase
		bm_w = {4{bm}};
		if (gfx_regs_q[5][1:0] != 2'd1) begin
			case (gfx_regs_q[3][4:3])
				2'd1: wr_val = wr_val & latch_q;
				2'd2: wr_val = wr_val | latch_q;
				2'd3: wr_val = wr_val ^ latch_q;
				default: wr_val = wr_val;
			endcase
			wr_val = (wr_val & bm_w) | (latch_q & ~bm_w);
		end
		wr_mask = lanes(seq_regs_q[2][3:0]);

		// byte modes write one plane of the word
		if (chain4 || oddeven) begin
			wr_val  = {4{data_s1}};
			wr_mask = lanes(plane_sel & seq_regs_q[2][3:0]);
		end
		merged = (rdata_q & ~wr_mask) | (wr_val & wr_mask);

		wr_hit   = (op_s1 == OP_WRITE) && emu && in_win;
		latch_ld = (op_s1 == OP_READ) && emu && in_win && !chain4 && !oddeven;
	end

	logic       is_seq_idx;
	logic       is_seq_dat;
	logic       is_gfx_idx;
	logic       is_gfx_dat;
	logic       seq_wr;
	logic       gfx_wr;
	logic [7:0] seq7_nxt;
	logic [7:0] gfx6_nxt;
	logic       std_nxt;
	logic       std_after;
	logic       caching_nxt;
	logic       handled_nxt;
	logic [7:0] rb_nxt;

	// port decode and mode flags
	always_comb begin
		is_seq_idx = (op_s1 == OP_PORT) && (addr_s1 == PORT_SEQ_INDEX);
		is_seq_dat = (op_s1 == OP_PORT) && (addr_s1 == PORT_SEQ_DATA);
		is_gfx_idx = (op_s1 == OP_PORT) && (addr_s1 == PORT_GFX_INDEX);
		is_gfx_dat = (op_s1 == OP_PORT) && (addr_s1 == PORT_GFX_DATA);
		seq_wr     = is_seq_dat && (seq_index_q[7:3] == 5'd0);
		gfx_wr     = is_gfx_dat && (gfx_index_q < GFX_REGS_B);

		seq7_nxt = (seq_wr && seq_index_q[2:0] == 3'd7) ?
			(data_s1 & seq_wmask(3'd7)) : seq_regs_q[7];
		gfx6_nxt = (gfx_wr && gfx_index_q[3:0] == 4'd6) ?
			(data_s1 & gfx_wmask(4'd6)) : gfx_regs_q[6];
		std_nxt  = (seq7_nxt == 8'h00) && (gfx6_nxt == GFX6_STD);

		std_after   = std_mode_q;
		caching_nxt = caching_q;
		handled_nxt = 1'b0;
		rb_nxt      = 8'h00;
		case (op_s1)
			OP_PORT: begin
				std_after   = std_nxt;
				caching_nxt = caching_q | (~std_mode_q & std_nxt);
				handled_nxt = is_seq_idx | is_gfx_idx | seq_wr | gfx_wr;
			end
			OP_READ: begin
				handled_nxt = emu;
				rb_nxt      = emu ? rd_byte : 8'h00;
			end
			OP_WRITE: handled_nxt = emu;
			default: begin
				if (emu) begin
					caching_nxt = 1'b0;
				end
			end
		endcase
	end

	// hold the item and fetch its memory word
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_s1   <= vpma_op_t'(in_op);
			addr_s1 <= in_address;
			data_s1 <= in_data;
			widx_s1 <= rd_idx;
		end
	end

	// video memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			vram[clr_q] <= '0;
		end else if (cmd.exec && wr_hit) begin
			vram[widx_s1] <= merged;
		end
		if (cmd.accept) begin
			rdata_q <= vram[rd_idx];
		end
	end

	// advance the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_q == LAST_WORD);

	// update registers, latch and mode flags at the end of an item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_index_q <= '0;
			gfx_index_q <= '0;
			for (int i = 0; i < SEQ_REGS; i++) begin
				seq_regs_q[i] <= '0;
			end
			for (int i = 0; i < GFX_REGS; i++) begin
				gfx_regs_q[i] <= '0;
			end
			latch_q    <= '0;
			std_mode_q <= 1'b0;
			caching_q  <= 1'b0;
		end else if (cmd.exec) begin
			if (is_seq_idx) begin
				seq_index_q <= data_s1;
			end
			if (is_gfx_idx) begin
				gfx_index_q <= data_s1;
			end
			for (int i = 0; i < SEQ_REGS; i++) begin
				if (seq_wr && seq_index_q[2:0] == 3'(i)) begin
					seq_regs_q[i] <= data_s1 & seq_wmask(3'(i));
				end
			end
			for (int i = 0; i < GFX_REGS; i++) begin
				if (gfx_wr && gfx_index_q[3:0] == 4'(i)) begin
					gfx_regs_q[i] <= data_s1 & gfx_wmask(4'(i));
				end
			end
			if (latch_ld) begin
				latch_q <= rdata_q;
			end
			std_mode_q <= std_after;
			caching_q  <= caching_nxt;
		end
	end

	// load the response register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			read_byte_q <= rb_nxt;
			handled_q   <= handled_nxt;
			emulating_q <= std_after & caching_nxt;
		end
	end

	assign read_byte = read_byte_q;
	assign handled   = handled_q;
	assign emulating = emulating_q;

endmodule

`default_nettype wire

// ----- hw/rtl/vpma_ctrl.sv -----
// ----------------------------------------------------------------------------
// vpma_ctrl
// Controller: clearing sweep after reset, request accept, execute step and
// response beat tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module vpma_ctrl import vpma_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  vpma_sts_t sts,
	output vpma_cmd_t cmd
);

	vpma_state_t state_q;
	vpma_state_t state_d;
	logic        out_valid_q;
	logic        out_valid_d;

	// state and response valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// finish only when the response register is free
				if (!out_valid_q || out_ready) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase

		if (cmd.exec) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/vga_planar_memory_access_top.sv -----
// ----------------------------------------------------------------------------
// vga_planar_memory_access_top
// Sequencer and graphics controller registers in front of a four-plane video
// memory, one byte access per request beat.
// ----------------------------------------------------------------------------
// Usage:
//   req carries op, address and data. Port writes go to 0x3c4/0x3c5 and
//   0x3ce/0x3cf; memory reads and writes are emulated only while standard
//   mode and caching are both on. rsp returns read_byte, handled and
//   emulating, exactly one beat per request beat, in order.
//   The accept edge fetches the memory word; the execute edge modifies it,
//   writes it back and loads the response register. A new request is taken
//   only once the previous one has executed. rsp.valid rises at the execute
//   edge. After reset all VRAM_WORDS words of video memory are swept to
//   zero, one word per cycle; req.ready stays low during the sweep.
//   A stalled response is held in its register; a new request is still taken
//   meanwhile, and it waits in its execute step until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vga_planar_memory_access_top_macros.svh"

module vga_planar_memory_access_top import vpma_pkg::*; #(
	parameter int VRAM_WORDS = 65536
) (
	input  logic clk,
	input  logic arst_n,
	vpma_in_if.sink    req,
	vpma_out_if.source rsp
);

	vpma_cmd_t cmd;
	vpma_sts_t sts;

	vpma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	vpma_dp #(
		.VRAM_WORDS (VRAM_WORDS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (req.op),
		.in_address (req.address),
		.in_data    (req.data),
		.read_byte  (rsp.read_byte),
		.handled    (rsp.handled),
		.emulating  (rsp.emulating)
	);

	// one request in flight: no accept right after an accept
	`VPMA_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req.valid && req.ready, !req.ready)

	// a nonzero read byte only comes from an emulated access
	`VPMA_ASSERT_IMPL(a_byte_handled, clk, arst_n, rsp.valid && rsp.read_byte != 8'h00, rsp.handled)

	// with the response register empty at accept, the execute step does not stall and rsp.valid rises at the execute edge
	`VPMA_ASSERT_IMPL(a_latency, clk, arst_n, $past(req.valid && req.ready && !rsp.valid, 2), rsp.valid)

endmodule

`default_nettype wire
